// ===== hdl/crcpfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the byte-wide CRC-16 update of the packet frame receiver.
package crcpfr_pkg;

	localparam logic [7:0]  START_BYTE       = 8'hA1;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [7:0]  MAX_LENGTH_RESET = 8'd200;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_GOOD    = 2'd1;
	localparam logic [1:0] EV_BAD     = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_TYPE    = 6'b000010,
		PH_LEN     = 6'b000100,
		PH_CRCLO   = 6'b001000,
		PH_CRCHI   = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [7:0]  index;
		logic [7:0]  ptype;
		logic [7:0]  plength;
		logic [15:0] crc;
	} result_t;

	// Reflected CCITT CRC-16 (polynomial 0x8408), one byte per call.
	function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
		logic [7:0] x;
		x = b ^ crc[7:0];
		x = x ^ {x[3:0], 4'b0000};
		return {x, 8'h00} ^ {8'h00, crc[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
	endfunction

endpackage

// ===== hdl/crcpfr_parser.sv =====
`timescale 1ns / 1ps
// Frame parser: phase register, header fields, running CRC and result decode.
module crcpfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	input  logic [7:0]           max_length,
	output crcpfr_pkg::result_t  res
);

	crcpfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  length_q, length_d;
	logic [15:0] hdr_crc_q, hdr_crc_d;
	logic [15:0] run_crc_q, run_crc_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] crc_next;
	logic [15:0] hdr_full;
	logic        more;

	assign crc_next = crcpfr_pkg::crc_step(byte_in, run_crc_q);
	assign hdr_full = {byte_in, hdr_crc_q[7:0]};
	assign more     = ({1'b0, count_q} + 9'd1) < {1'b0, length_q};

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		length_d  = length_q;
		hdr_crc_d = hdr_crc_q;
		run_crc_d = run_crc_q;
		count_d   = count_q;
		res       = '0;
		res.ptype   = type_q;
		res.plength = length_q;
		res.crc     = hdr_crc_q;
		case (phase_q)
			crcpfr_pkg::PH_TYPE: begin
				type_d    = byte_in;
				run_crc_d = crc_next;
				phase_d   = crcpfr_pkg::PH_LEN;
			end
			crcpfr_pkg::PH_LEN: begin
				if (byte_in > max_length) begin
					res.emit    = 1'b1;
					res.kind    = crcpfr_pkg::EV_REJECT;
					res.plength = byte_in;
					res.crc     = '0;
					phase_d     = crcpfr_pkg::PH_HUNT;
				end else begin
					length_d  = byte_in;
					run_crc_d = crc_next;
					phase_d   = crcpfr_pkg::PH_CRCLO;
				end
			end
			crcpfr_pkg::PH_CRCLO: begin
				hdr_crc_d = {8'h00, byte_in};
				phase_d   = crcpfr_pkg::PH_CRCHI;
			end
			crcpfr_pkg::PH_CRCHI: begin
				hdr_crc_d = hdr_full;
				count_d   = '0;
				if (length_q == 8'd0) begin
					// Empty packet: the verdict comes with the second CRC byte.
					res.emit = 1'b1;
					res.kind = (run_crc_q == hdr_full) ? crcpfr_pkg::EV_GOOD
						: crcpfr_pkg::EV_BAD;
					res.crc  = hdr_full;
					phase_d  = crcpfr_pkg::PH_HUNT;
				end else begin
					phase_d = crcpfr_pkg::PH_PAYLOAD;
				end
			end
			crcpfr_pkg::PH_PAYLOAD: begin
				run_crc_d = crc_next;
				count_d   = count_q + 8'd1;
				res.emit  = 1'b1;
				res.value = byte_in;
				res.index = count_q;
				if (more) begin
					res.kind = crcpfr_pkg::EV_PAYLOAD;
				end else begin
					// The last payload byte carries the verdict instead.
					res.kind = (crc_next == hdr_crc_q) ? crcpfr_pkg::EV_GOOD
						: crcpfr_pkg::EV_BAD;
					phase_d  = crcpfr_pkg::PH_HUNT;
				end
			end
			default: begin
				phase_d = crcpfr_pkg::PH_HUNT;
				if (byte_in == crcpfr_pkg::START_BYTE) begin
					run_crc_d = crcpfr_pkg::CRC_INIT;
					phase_d   = crcpfr_pkg::PH_TYPE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crcpfr_pkg::PH_HUNT;
			type_q    <= '0;
			length_q  <= '0;
			hdr_crc_q <= '0;
			run_crc_q <= crcpfr_pkg::CRC_INIT;
			count_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			length_q  <= length_d;
			hdr_crc_q <= hdr_crc_d;
			run_crc_q <= run_crc_d;
			count_q   <= count_d;
		end
	end

endmodule

// ===== hdl/crc_packet_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// Top level of the packet frame receiver: input register, parser, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  input    | in_valid / in_stall         | data_byte
//  result   | out_valid / out_stall       | event_kind, data_value, data_index,
//           |                             | packet_type, packet_length, received_crc
//  config   | cfg_valid / cfg_ready       | max_length
//
// One byte is taken per clock while in_stall is low. A byte is captured in the input register, decoded by the
// parser in the following cycle and, when it yields an event, lands in the result register
// once that register is free to take it. The rate
// is set by the single byte-wide CRC update and phase decode between the two registers.
// Reset puts the parser in the start-byte hunt, the CRC at all ones and max_length at 200.
// A stalled result holds the result register; bytes that give no event still pass through,
// and only a byte that would give an event waits, which then stalls the input.
module crc_packet_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [7:0]  data_value,
	output logic [7:0]  data_index,
	output logic [7:0]  packet_type,
	output logic [7:0]  packet_length,
	output logic [15:0] received_crc,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  max_length
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [7:0]          max_len_q;
	logic                out_valid_q;
	logic                out_free;
	logic                adv;
	crcpfr_pkg::result_t res;
	crcpfr_pkg::result_t out_q;

	// The limit register takes a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= crcpfr_pkg::MAX_LENGTH_RESET;
		end else if (cfg_valid) begin
			max_len_q <= max_length;
		end
	end

	// The result register can take a new event when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	// A buffered byte moves into the parser unless its event has nowhere to go.
	assign adv      = valid_s1 && (out_free || !res.emit);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	crcpfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.byte_in    (byte_s1),
		.max_length (max_len_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv && res.emit) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_q.kind;
	assign data_value    = out_q.value;
	assign data_index    = out_q.index;
	assign packet_type   = out_q.ptype;
	assign packet_length = out_q.plength;
	assign received_crc  = out_q.crc;

`ifndef NO_ASSERTIONS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no buffered byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && res.emit) |-> !adv)
		else $error("pending result would be overwritten");

	a_stalled_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1))
		else $error("buffered byte lost during stall");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == crcpfr_pkg::EV_PAYLOAD) |-> data_index < packet_length)
		else $error("payload index beyond packet length");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == crcpfr_pkg::EV_REJECT) |->
		(received_crc == 16'h0000 && data_value == 8'h00 && data_index == 8'h00))
		else $error("rejected length event carries stale fields");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the packet frame receiver: framing, CRC verdicts and length limit.
module tb_top;

	// Reflected CCITT polynomial. The testbench computes the CRC one bit at a time, so it
	// does not depend on the table-free byte form used in the RTL.
	localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;
	// A byte reaches the result register through the input register and the parser. The extra
	// TAIL_CYCLES wait lets bytes that give no event finish before the next register write.
	localparam int TAIL_CYCLES = 6;
	localparam int PHASE_BYTES = 30;
	localparam int DRAIN_LIMIT = 5000;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [7:0]  index;
		logic [7:0]  ptype;
		logic [7:0]  plength;
		logic [15:0] crc;
	} rx_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  data_value;
	logic [7:0]  data_index;
	logic [7:0]  packet_type;
	logic [7:0]  packet_length;
	logic [15:0] received_crc;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  max_length = 8'h00;

	crc_packet_frame_receiver_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.data_value    (data_value),
		.data_index    (data_index),
		.packet_type   (packet_type),
		.packet_length (packet_length),
		.received_crc  (received_crc),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.max_length    (max_length)
	);

	// Deframer state as the testbench tracks it, updated on every accepted byte transfer.
	crcpfr_pkg::phase_t rx_phase   = crcpfr_pkg::PH_HUNT;
	logic [7:0]         rx_limit   = crcpfr_pkg::MAX_LENGTH_RESET;
	logic [7:0]         rx_type    = 8'h00;
	logic [7:0]         rx_length  = 8'h00;
	logic [15:0]        rx_hdr_crc = 16'h0000;
	logic [15:0]        rx_crc     = crcpfr_pkg::CRC_INIT;
	logic [7:0]         rx_count   = 8'h00;

	rx_event_t pending_events[$];

	// Handshake pressure of the current phase, in percent of cycles.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Limit the stimulus generator believes is programmed; the predictor keeps its own.
	int gen_limit = crcpfr_pkg::MAX_LENGTH_RESET;

	int failures       = 0;
	int frame_bytes    = 0;
	int bytes_accepted = 0;
	int limit_writes   = 0;
	int n_payload      = 0;
	int n_good         = 0;
	int n_bad          = 0;
	int n_reject       = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [15:0] crc16_mcrf_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
		end
		return c;
	endfunction

	// Advances the deframer by one byte and queues the event it gives, if any.
	function automatic void deframe_byte(input logic [7:0] b);
		rx_event_t ev;
		bit        fire;
		fire = 1'b0;
		ev = '0;
		case (rx_phase)
			crcpfr_pkg::PH_TYPE: begin
				rx_type = b;
				rx_crc = crc16_mcrf_byte(rx_crc, b);
				rx_phase = crcpfr_pkg::PH_LEN;
			end
			crcpfr_pkg::PH_LEN: begin
				if (b > rx_limit) begin
					// Rejected length: only type and the offending length are reported.
					ev.kind = crcpfr_pkg::EV_REJECT;
					ev.ptype = rx_type;
					ev.plength = b;
					fire = 1'b1;
					rx_phase = crcpfr_pkg::PH_HUNT;
				end else begin
					rx_length = b;
					rx_crc = crc16_mcrf_byte(rx_crc, b);
					rx_phase = crcpfr_pkg::PH_CRCLO;
				end
			end
			crcpfr_pkg::PH_CRCLO: begin
				rx_hdr_crc = {8'h00, b};
				rx_phase = crcpfr_pkg::PH_CRCHI;
			end
			crcpfr_pkg::PH_CRCHI: begin
				rx_hdr_crc[15:8] = b;
				rx_count = 8'h00;
				if (rx_length == 8'h00) begin
					// An empty packet gets its verdict on the CRC high byte.
					ev.kind = (rx_crc == rx_hdr_crc) ? crcpfr_pkg::EV_GOOD
						: crcpfr_pkg::EV_BAD;
					ev.ptype = rx_type;
					ev.plength = rx_length;
					ev.crc = rx_hdr_crc;
					fire = 1'b1;
					rx_phase = crcpfr_pkg::PH_HUNT;
				end else begin
					rx_phase = crcpfr_pkg::PH_PAYLOAD;
				end
			end
			crcpfr_pkg::PH_PAYLOAD: begin
				rx_crc = crc16_mcrf_byte(rx_crc, b);
				ev.value = b;
				ev.index = rx_count;
				ev.ptype = rx_type;
				ev.plength = rx_length;
				ev.crc = rx_hdr_crc;
				fire = 1'b1;
				if (int'(rx_count) + 1 < int'(rx_length)) begin
					ev.kind = crcpfr_pkg::EV_PAYLOAD;
				end else begin
					// The last payload byte carries the verdict instead of a payload event.
					ev.kind = (rx_crc == rx_hdr_crc) ? crcpfr_pkg::EV_GOOD
						: crcpfr_pkg::EV_BAD;
					rx_phase = crcpfr_pkg::PH_HUNT;
				end
				rx_count = rx_count + 8'd1;
			end
			default: begin
				rx_phase = crcpfr_pkg::PH_HUNT;
				if (b == crcpfr_pkg::START_BYTE) begin
					rx_crc = crcpfr_pkg::CRC_INIT;
					rx_phase = crcpfr_pkg::PH_TYPE;
				end
			end
		endcase
		if (fire) begin
			pending_events.push_back(ev);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
					      input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	function automatic void check_event();
		rx_event_t want;
		if (pending_events.size() == 0) begin
			$error("Unexpected result transfer: event_kind %0d, data_value 0x%0h",
			       event_kind, data_value);
			failures++;
			return;
		end
		want = pending_events.pop_front();
		compare_field("event_kind", want.kind, event_kind);
		compare_field("data_value", want.value, data_value);
		compare_field("data_index", want.index, data_index);
		compare_field("packet_type", want.ptype, packet_type);
		compare_field("packet_length", want.plength, packet_length);
		compare_field("received_crc", want.crc, received_crc);
		case (want.kind)
			crcpfr_pkg::EV_PAYLOAD: n_payload++;
			crcpfr_pkg::EV_GOOD:    n_good++;
			crcpfr_pkg::EV_BAD:     n_bad++;
			default:                n_reject++;
		endcase
	endfunction

	// Random receiver stall; a zero percentage keeps the result channel always open.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Transfers are observed on the edge where they happen, before any update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_event();
			end
			if (in_valid && !in_stall) begin
				deframe_byte(data_byte);
				bytes_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				rx_limit = max_length;
			end
		end
	end

	// Offers one byte, with random idle cycles ahead of it, and returns once it transfers.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic byte_q_t random_body(input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++) begin
			q.push_back(8'($urandom));
		end
		return q;
	endfunction

	// Sends a framed packet. A corrupted frame carries a wrong header CRC; a nonnegative
	// cut no larger than the frame stops the frame after that many bytes.
	task automatic send_frame(input logic [7:0] ptype, input byte_q_t body, input bit corrupt,
				  input int cut);
		byte_q_t     wire_q;
		logic [7:0]  len;
		logic [15:0] crc;
		int          n;
		len = 8'(body.size());
		crc = crc16_mcrf_byte(crcpfr_pkg::CRC_INIT, ptype);
		crc = crc16_mcrf_byte(crc, len);
		foreach (body[i]) begin
			crc = crc16_mcrf_byte(crc, body[i]);
		end
		if (corrupt) begin
			crc = crc ^ 16'($urandom_range(1, 65535));
		end
		wire_q.push_back(crcpfr_pkg::START_BYTE);
		wire_q.push_back(ptype);
		wire_q.push_back(len);
		wire_q.push_back(crc[7:0]);
		wire_q.push_back(crc[15:8]);
		foreach (body[i]) begin
			wire_q.push_back(body[i]);
		end
		n = (cut < 0 || cut > wire_q.size()) ? wire_q.size() : cut;
		for (int i = 0; i < n; i++) begin
			send_byte(wire_q[i]);
			frame_bytes++;
		end
	endtask

	task automatic send_rejected(input logic [7:0] ptype, input logic [7:0] len);
		send_byte(crcpfr_pkg::START_BYTE);
		send_byte(ptype);
		send_byte(len);
		frame_bytes += 3;
	endtask

	// Lets every expected event arrive and the pipeline empty out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		max_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_limit = v;
		limit_writes++;
	endtask

	// Hand-built frames under the reset limit: extreme type and payload values, both
	// verdicts, an empty packet, a start byte inside a frame and a rejected length.
	task automatic test_directed_frames();
		byte_q_t body;
		send_frame(8'h00, body, 1'b0, -1);
		send_frame(8'hFF, body, 1'b1, -1);
		body.push_back(8'hFF);
		body.push_back(8'h00);
		send_frame(8'h5A, body, 1'b0, -1);
		body.delete();
		body.push_back(crcpfr_pkg::START_BYTE);
		send_frame(crcpfr_pkg::START_BYTE, body, 1'b1, -1);
		send_rejected(8'h3C, crcpfr_pkg::MAX_LENGTH_RESET + 8'd1);
	endtask

	// Length limit at its extremes and at a boundary, including the longest packet.
	task automatic test_length_limit();
		byte_q_t no_body;
		write_limit(8'd0);
		send_frame(8'($urandom), no_body, 1'b0, -1);
		send_rejected(8'h11, 8'd1);
		send_rejected(8'h22, 8'd255);
		write_limit(8'd7);
		send_frame(8'($urandom), random_body(7), 1'b0, -1);
		send_rejected(8'h33, 8'd8);
		write_limit(8'd255);
		send_frame(8'h80, random_body(255), 1'b0, -1);
	endtask

	// Mostly well-formed frames with random content, plus bad CRCs, rejected lengths,
	// truncated frames and line noise, over four handshake pressure phases.
	task automatic test_random_traffic();
		int         phase_idle[4]  = '{0, 50, 0, 28};
		int         phase_stall[4] = '{0, 0, 50, 28};
		int         budget_end;
		int         pick;
		int         len;
		int         short_max;
		logic [7:0] ptype;
		for (int p = 0; p < 4; p++) begin
			write_limit((p == 3) ? 8'd255 : 8'($urandom_range(6, 254)));
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			budget_end = frame_bytes + PHASE_BYTES;
			while (frame_bytes < budget_end) begin
				pick = $urandom_range(99);
				short_max = (gen_limit < 12) ? gen_limit : 12;
				len = $urandom_range(0, short_max);
				if ($urandom_range(19) == 0) begin
					len = $urandom_range(0, (gen_limit < 40) ? gen_limit : 40);
				end
				ptype = 8'($urandom);
				if (pick < 55) begin
					send_frame(ptype, random_body(len), 1'b0, -1);
				end else if (pick < 70 || (pick < 78 && gen_limit == 255)) begin
					send_frame(ptype, random_body(len), 1'b1, -1);
				end else if (pick < 78) begin
					send_rejected(ptype, 8'($urandom_range(gen_limit + 1, 255)));
				end else if (pick < 86) begin
					send_frame(ptype, random_body(len), 1'b0, $urandom_range(1, len + 4));
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
				end
			end
		end
	endtask

	initial begin
		int settle;
		settle = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_length_limit();
		test_random_traffic();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0 && settle < DRAIN_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_events.size() != 0) begin
			$error("%0d expected results never arrived", pending_events.size());
			failures += pending_events.size();
		end
		$display("Covered %0d byte transfers: %0d payload, %0d good CRC, %0d bad CRC, %0d rejected.",
			 bytes_accepted, n_payload, n_good, n_bad, n_reject);
		$display("Length limit written %0d times, four pressure phases on both channels.",
			 limit_writes);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
